// ----- hdl/u8vcc_pkg.sv -----
// Shared constants and types for the UTF-8 validating character counter.
`default_nettype none

package u8vcc_pkg;

    // Width of the internal character counter
    localparam int COUNT_BITS = 32;
    // Width of the reported count
    localparam int OUT_BITS   = 32;
    // Working width for the output saturation compare
    localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

    localparam int BYTE_BITS  = 8;

    // Byte boundaries of the UTF-8 grammar
    localparam logic [BYTE_BITS-1:0] BYTE_NUL       = 8'h00;
    localparam logic [BYTE_BITS-1:0] BYTE_ASCII_MAX = 8'h7f;
    localparam logic [BYTE_BITS-1:0] BYTE_CONT_MIN  = 8'h80;
    localparam logic [BYTE_BITS-1:0] BYTE_CONT_8F   = 8'h8f;
    localparam logic [BYTE_BITS-1:0] BYTE_CONT_90   = 8'h90;
    localparam logic [BYTE_BITS-1:0] BYTE_CONT_A0   = 8'ha0;
    localparam logic [BYTE_BITS-1:0] BYTE_CONT_MAX  = 8'hbf;
    localparam logic [BYTE_BITS-1:0] BYTE_LEAD2_MIN = 8'hc2;
    localparam logic [BYTE_BITS-1:0] BYTE_LEAD2_MAX = 8'hdf;
    localparam logic [BYTE_BITS-1:0] BYTE_E0        = 8'he0;
    localparam logic [BYTE_BITS-1:0] BYTE_E1        = 8'he1;
    localparam logic [BYTE_BITS-1:0] BYTE_EF        = 8'hef;
    localparam logic [BYTE_BITS-1:0] BYTE_F0        = 8'hf0;
    localparam logic [BYTE_BITS-1:0] BYTE_F1        = 8'hf1;
    localparam logic [BYTE_BITS-1:0] BYTE_F3        = 8'hf3;
    localparam logic [BYTE_BITS-1:0] BYTE_F4        = 8'hf4;

    // Continuation bytes still expected
    localparam int PEND_BITS = 2;
    localparam logic [PEND_BITS-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_BITS-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_BITS-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_BITS-1:0] PEND_THREE = 2'd3;

    // Allowed range of the next continuation byte
    typedef enum logic [1:0] {
        CLS_80_BF = 2'd0,
        CLS_A0_BF = 2'd1,
        CLS_90_BF = 2'd2,
        CLS_80_8F = 2'd3
    } range_class_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [WIDE_BITS-1:0]  OUT_MAX_WIDE =
        WIDE_BITS'({OUT_BITS{1'b1}});

endpackage

`default_nettype wire

// ----- hdl/utf8_validate_char_counter.sv -----
// Top level: UTF-8 validating character counter on a byte stream.
`default_nettype none

// Takes a NUL-terminated UTF-8 string one byte per request on the s_ side and
// returns one request on the m_ side per string: the character count with
// m_tuser high when the string is well formed, or count zero with m_tuser low
// at the first bad byte (the rest of the string up to its zero byte is then
// skipped and produces nothing). An input register feeds the decode logic,
// which updates the parse state and loads the result register in the same
// cycle, so a byte is accepted every cycle while the result register is
// empty or being drained. m_tvalid rises once the terminating byte has moved
// from the input register into the result register. The count saturates.
module utf8_validate_char_counter
    import u8vcc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata: [7:0] text_byte
    input  wire logic [BYTE_BITS-1:0]  s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // m_tdata: [31:0] char_count
    output logic [OUT_BITS-1:0]        m_tdata,
    // m_tuser: [0] is_valid
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready
);

    // Input register
    logic                  in_valid_reg, in_valid_next;
    logic [BYTE_BITS-1:0]  in_byte_reg;

    // Parse state
    logic [PEND_BITS-1:0]  pending_reg, pending_next;
    range_class_t          class_reg, class_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  discard_reg, discard_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_count_reg;
    logic                  out_ok_reg;

    logic                  advance;
    logic                  has_result;
    logic [OUT_BITS-1:0]   res_count;
    logic                  res_ok;
    logic                  cont_ok;
    logic [COUNT_BITS-1:0] count_bumped;
    logic [WIDE_BITS-1:0]  count_wide;
    logic [BYTE_BITS-1:0]  b;

    // Byte moves out of the input register when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign b = in_byte_reg;

    // Continuation byte range check
    always_comb begin
        case (class_reg)
            CLS_A0_BF: cont_ok = (b >= BYTE_CONT_A0)  && (b <= BYTE_CONT_MAX);
            CLS_90_BF: cont_ok = (b >= BYTE_CONT_90)  && (b <= BYTE_CONT_MAX);
            CLS_80_8F: cont_ok = (b >= BYTE_CONT_MIN) && (b <= BYTE_CONT_8F);
            default:   cont_ok = (b >= BYTE_CONT_MIN) && (b <= BYTE_CONT_MAX);
        endcase
    end

    // Saturating increment and saturated output count
    assign count_bumped = (count_reg == COUNT_MAX) ? count_reg
                                                   : count_reg + COUNT_BITS'(1);
    assign count_wide   = WIDE_BITS'(count_reg);

    // Decode one byte
    always_comb begin
        pending_next = pending_reg;
        class_next   = class_reg;
        count_next   = count_reg;
        discard_next = discard_reg;
        has_result   = 1'b0;
        res_count    = '0;
        res_ok       = 1'b0;

        if (discard_reg) begin
            // skip up to the terminator
            if (b == BYTE_NUL) begin
                pending_next = PEND_NONE;
                class_next   = CLS_80_BF;
                count_next   = '0;
                discard_next = 1'b0;
            end
        end else if (pending_reg != PEND_NONE) begin
            if (cont_ok) begin
                pending_next = pending_reg - PEND_BITS'(1);
                class_next   = CLS_80_BF;
                if (pending_reg == PEND_ONE) begin
                    count_next = count_bumped;
                end
            end else begin
                has_result   = 1'b1;
                pending_next = PEND_NONE;
                class_next   = CLS_80_BF;
                count_next   = '0;
                discard_next = (b != BYTE_NUL);
            end
        end else if (b == BYTE_NUL) begin
            // terminator at a character boundary
            has_result   = 1'b1;
            res_ok       = 1'b1;
            res_count    = (count_wide > OUT_MAX_WIDE) ? {OUT_BITS{1'b1}}
                                                       : count_wide[OUT_BITS-1:0];
            pending_next = PEND_NONE;
            class_next   = CLS_80_BF;
            count_next   = '0;
        end else if (b <= BYTE_ASCII_MAX) begin
            count_next = count_bumped;
        end else if ((b >= BYTE_LEAD2_MIN) && (b <= BYTE_LEAD2_MAX)) begin
            pending_next = PEND_ONE;
            class_next   = CLS_80_BF;
        end else if (b == BYTE_E0) begin
            pending_next = PEND_TWO;
            class_next   = CLS_A0_BF;
        end else if ((b >= BYTE_E1) && (b <= BYTE_EF)) begin
            pending_next = PEND_TWO;
            class_next   = CLS_80_BF;
        end else if (b == BYTE_F0) begin
            pending_next = PEND_THREE;
            class_next   = CLS_90_BF;
        end else if ((b >= BYTE_F1) && (b <= BYTE_F3)) begin
            pending_next = PEND_THREE;
            class_next   = CLS_80_BF;
        end else if (b == BYTE_F4) begin
            pending_next = PEND_THREE;
            class_next   = CLS_80_8F;
        end else begin
            // bad lead byte
            has_result   = 1'b1;
            pending_next = PEND_NONE;
            class_next   = CLS_80_BF;
            count_next   = '0;
            discard_next = 1'b1;
        end
    end

    // Handshake bookkeeping
    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = has_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= PEND_NONE;
            class_reg     <= CLS_80_BF;
            count_reg     <= '0;
            discard_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                pending_reg <= pending_next;
                class_reg   <= class_next;
                count_reg   <= count_next;
                discard_reg <= discard_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && has_result) begin
            out_count_reg <= res_count;
            out_ok_reg    <= res_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_ok_reg;

    // An invalid result always reports a zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid result with nonzero count");

    // While skipping, no continuation is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        discard_reg |-> (pending_reg == PEND_NONE))
        else $error("skipping with a sequence still open");

    // A special first-byte range only exists while a sequence is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        (class_reg != CLS_80_BF) |-> (pending_reg != PEND_NONE))
        else $error("range class set at a character boundary");

    // Bytes consumed while skipping never produce a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && discard_reg) |=> !m_tvalid)
        else $error("result produced while skipping");

endmodule

`default_nettype wire

// ----- sim/utf8_count_checker.sv -----
// Checker for the UTF-8 character counter: predicts each string report and compares it.
module utf8_count_checker
    import u8vcc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [BYTE_BITS-1:0] s_tdata,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [OUT_BITS-1:0]  m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    output int                        fail_count,
    output int                        reports_waiting,
    output int                        valid_reports,
    output int                        bad_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [OUT_BITS-1:0] char_count;
        logic                is_valid;
    } string_report_t;

    // Predicted parse state
    logic [PEND_BITS-1:0]  pend;
    range_class_t          cls;
    logic [COUNT_BITS-1:0] run_count;
    logic                  skipping;

    string_report_t expected_reports[$];

    initial begin
        fail_count      = 0;
        reports_waiting = 0;
        valid_reports   = 0;
        bad_reports     = 0;
    end

    task automatic clear_string();
        pend      = PEND_NONE;
        cls       = CLS_80_BF;
        run_count = '0;
        skipping  = 1'b0;
    endtask

    task automatic bump_count();
        if (run_count != COUNT_MAX) begin
            run_count = run_count + 1'b1;
        end
    endtask

    // Bad byte: report count zero, skip to the terminator unless this is it
    task automatic flag_bad(input logic [BYTE_BITS-1:0] b);
        expected_reports.push_back('{char_count: '0, is_valid: 1'b0});
        clear_string();
        if (b != BYTE_NUL) begin
            skipping = 1'b1;
        end
    endtask

    // Advance the predicted parse by one byte
    task automatic decode_byte(input logic [BYTE_BITS-1:0] b);
        logic                 in_range;
        logic [WIDE_BITS-1:0] wide_count;
        string_report_t       rep;
        if (skipping) begin
            if (b == BYTE_NUL) begin
                clear_string();
            end
        end else if (pend != PEND_NONE) begin
            case (cls)
                CLS_A0_BF: in_range = (b >= BYTE_CONT_A0) && (b <= BYTE_CONT_MAX);
                CLS_90_BF: in_range = (b >= BYTE_CONT_90) && (b <= BYTE_CONT_MAX);
                CLS_80_8F: in_range = (b >= BYTE_CONT_MIN) && (b <= BYTE_CONT_8F);
                default:   in_range = (b >= BYTE_CONT_MIN) && (b <= BYTE_CONT_MAX);
            endcase
            if (!in_range) begin
                flag_bad(b);
            end else begin
                pend = pend - 1'b1;
                cls  = CLS_80_BF;
                if (pend == PEND_NONE) begin
                    bump_count();
                end
            end
        end else if (b == BYTE_NUL) begin
            // terminator at a character boundary: report the (saturated) count
            wide_count = WIDE_BITS'(run_count);
            if (wide_count > OUT_MAX_WIDE) begin
                rep.char_count = OUT_BITS'(OUT_MAX_WIDE);
            end else begin
                rep.char_count = OUT_BITS'(wide_count);
            end
            rep.is_valid = 1'b1;
            expected_reports.push_back(rep);
            clear_string();
        end else if (b <= BYTE_ASCII_MAX) begin
            bump_count();
        end else if (b >= BYTE_LEAD2_MIN && b <= BYTE_LEAD2_MAX) begin
            pend = PEND_ONE;
            cls  = CLS_80_BF;
        end else if (b == BYTE_E0) begin
            pend = PEND_TWO;
            cls  = CLS_A0_BF;
        end else if (b >= BYTE_E1 && b <= BYTE_EF) begin
            pend = PEND_TWO;
            cls  = CLS_80_BF;
        end else if (b == BYTE_F0) begin
            pend = PEND_THREE;
            cls  = CLS_90_BF;
        end else if (b >= BYTE_F1 && b <= BYTE_F3) begin
            pend = PEND_THREE;
            cls  = CLS_80_BF;
        end else if (b == BYTE_F4) begin
            pend = PEND_THREE;
            cls  = CLS_80_8F;
        end else begin
            flag_bad(b);
        end
    endtask

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
    endtask

    // Watch both channels at each rising edge
    always @(posedge aclk) begin
        string_report_t want;
        if (!aresetn) begin
            clear_string();
            expected_reports.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    note_failure($sformatf("unexpected report: count %0d valid %0b",
                                           m_tdata, m_tuser));
                end else begin
                    want = expected_reports.pop_front();
                    if (m_tdata !== want.char_count || m_tuser !== want.is_valid) begin
                        note_failure($sformatf(
                            "report mismatch: expected count %0d valid %0b, got count %0d valid %0b",
                            want.char_count, want.is_valid, m_tdata, m_tuser));
                    end
                    if (want.is_valid) begin
                        valid_reports++;
                    end else begin
                        bad_reports++;
                    end
                end
            end
        end
        reports_waiting = expected_reports.size();
    end

endmodule

// ----- sim/tb_utf8_validate_char_counter.sv -----
// Testbench top for the UTF-8 validating character counter: stimulus and verdict.
module tb_utf8_validate_char_counter;
    import u8vcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_TARGET = 900;
    localparam int CYCLE_LIMIT = 200_000;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [BYTE_BITS-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [OUT_BITS-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    int fail_count;
    int reports_waiting;
    int valid_reports;
    int bad_reports;

    int cycle_count   = 0;
    int bytes_sent    = 0;
    int strings_sent  = 0;
    bit calm          = 1'b0;

    logic [BYTE_BITS-1:0] text_buf[$];

    utf8_validate_char_counter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    utf8_count_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .fail_count      (fail_count),
        .reports_waiting (reports_waiting),
        .valid_reports   (valid_reports),
        .bad_reports     (bad_reports)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side back-pressure, off during the calm stretch
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 12);
    end

    // One byte request; entered and left at a falling edge
    task automatic push_byte(input logic [BYTE_BITS-1:0] b);
        while (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text();
        foreach (text_buf[i]) push_byte(text_buf[i]);
        text_buf.delete();
        strings_sent++;
    endtask

    // Append one well-formed character of random length and content
    task automatic add_char();
        int lead;
        case ($urandom_range(0, 4))
            0, 1: text_buf.push_back(BYTE_BITS'($urandom_range(1, BYTE_ASCII_MAX)));
            2: begin
                text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_LEAD2_MIN, BYTE_LEAD2_MAX)));
                text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_MIN, BYTE_CONT_MAX)));
            end
            3: begin
                lead = $urandom_range(BYTE_E0, BYTE_EF);
                text_buf.push_back(BYTE_BITS'(lead));
                if (lead == BYTE_E0) begin
                    text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_A0, BYTE_CONT_MAX)));
                end else begin
                    text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_MIN, BYTE_CONT_MAX)));
                end
                text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_MIN, BYTE_CONT_MAX)));
            end
            default: begin
                lead = $urandom_range(BYTE_F0, BYTE_F4);
                text_buf.push_back(BYTE_BITS'(lead));
                if (lead == BYTE_F0) begin
                    text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_90, BYTE_CONT_MAX)));
                end else if (lead == BYTE_F4) begin
                    text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_MIN, BYTE_CONT_8F)));
                end else begin
                    text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_MIN, BYTE_CONT_MAX)));
                end
                text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_MIN, BYTE_CONT_MAX)));
                text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_CONT_MIN, BYTE_CONT_MAX)));
            end
        endcase
    endtask

    // Mostly clean strings, some corrupted, some pure noise; always terminated
    task automatic send_random_string();
        int kind;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            n = $urandom_range(0, 10);
            repeat (n) add_char();
            if (kind >= 70) begin
                if (text_buf.size() > 0 && $urandom_range(0, 1)) begin
                    // overwrite one byte with anything at all
                    text_buf[$urandom_range(0, text_buf.size() - 1)] =
                        BYTE_BITS'($urandom_range(0, 255));
                end else begin
                    // lone byte from c2 up (a lead byte or a bad one) cut off by the terminator
                    text_buf.push_back(BYTE_BITS'($urandom_range(BYTE_LEAD2_MIN, 255)));
                end
            end
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) text_buf.push_back(BYTE_BITS'($urandom_range(0, 255)));
        end
        text_buf.push_back(BYTE_NUL);
        send_text();
    endtask

    initial begin
        // hold reset, then release it at a falling edge
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty string
        text_buf = '{BYTE_NUL};
        send_text();
        // ASCII and lead bytes c2, df, e0, ed, f0, f4, a surrogate included: 8 characters
        text_buf = '{8'h01, 8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf, 8'he0, 8'ha0, 8'hbf,
                     8'hed, 8'hbf, 8'h80, 8'hf0, 8'h90, 8'h80, 8'h80,
                     8'hf4, 8'h8f, 8'hbf, 8'hbf, BYTE_NUL};
        send_text();
        // bad lead bytes, then skip to the terminator
        text_buf = '{8'hc1, BYTE_NUL};
        send_text();
        text_buf = '{8'h80, 8'hff, BYTE_NUL};
        send_text();
        // first continuation out of its lead-specific range
        text_buf = '{8'he0, 8'h9f, BYTE_NUL};
        send_text();
        text_buf = '{8'hf4, 8'h90, BYTE_NUL};
        send_text();
        // terminator inside a sequence ends the string at once
        text_buf = '{8'hc2, BYTE_NUL};
        send_text();

        // random strings with a quiet stretch in the middle
        while (bytes_sent < BYTE_TARGET) begin
            calm = (bytes_sent >= 350) && (bytes_sent < 550);
            send_random_string();
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (reports_waiting != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("Sent %0d bytes in %0d strings; checked %0d reports (%0d valid, %0d rejected).",
                 bytes_sent, strings_sent, valid_reports + bad_reports,
                 valid_reports, bad_reports);
        if (fail_count == 0 && reports_waiting == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/u8vcc_pkg.sv
hdl/utf8_validate_char_counter.sv
sim/utf8_count_checker.sv
sim/tb_utf8_validate_char_counter.sv
